/* rtl/spu_pkg.sv */
package spu_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int RADIUS_BITS    = 16;
    localparam int OUT_BITS       = 27;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // pi as a 60-bit fraction, split in two 32-bit halves
    localparam int          PI_FRAC_BITS = 60;
    localparam logic [31:0] PI_Q60_HI    = 32'h3243F6A8;
    localparam logic [31:0] PI_Q60_LO    = 32'h885A308D;
    localparam int          PROD_BITS    = RADIUS_BITS + 32;
    localparam int          LOW_BITS     = PI_FRAC_BITS;
    // 2*pi*r: drop 60 fraction bits of pi, less one for the factor two, less 32 consumed by the low half
    localparam int          CIRC_SHIFT   = PI_FRAC_BITS - 32 - 1;

    typedef enum logic [1:0] {
        OP_CIRCLE = 2'd0,
        OP_RECT   = 2'd1,
        OP_TRI    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

/* rtl/shape_perimeter_unit.sv */
// Channel   Dir  tdata (low bit up)                    tuser
// s_axis    in   ax ay bx by cx cy radius, zero pad    operation
// m_axis    out  perimeter (Q.FRAC_BITS), zero pad     -
//
// One word per cycle enters and leaves while m_axis takes words; the path
// runs through the front stages, the square-root cell chain with one cell
// per result bit, NIT = COORD_BITS + 1 + FRAC_BITS, and the output register.
// Every stage holds its own valid bit, so bubbles close up under a stall
// on m_axis and s_axis keeps taking words until the chain is full.
// rst_n clears all valid bits asynchronously; payload registers hold junk.
module shape_perimeter_unit #(
    parameter int COORD_BITS = spu_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spu_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // ax, ay, bx, by, cx, cy, radius, zero pad
    input  logic [((6*COORD_BITS+spu_pkg::RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic [1:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // perimeter, zero pad
    output logic [spu_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata
);

    localparam int C    = COORD_BITS;
    localparam int SQW  = 2 * C + 2 + 2 * FRAC_BITS;
    localparam int NIT  = SQW / 2;
    localparam int FIXW = ((C + 2 > 22) ? C + 2 : 22) + FRAC_BITS;
    localparam int PW0  = (FIXW > NIT + 2) ? FIXW : NIT + 2;
    localparam int PW   = (PW0 > spu_pkg::OUT_BITS) ? PW0 : spu_pkg::OUT_BITS + 1;

    logic [5:0][C-1:0]  coord;
    logic [NIT:0]       ch_valid;
    logic [NIT:0]       ch_ready;
    spu_pkg::op_t       ch_op    [NIT+1];
    logic [FIXW-1:0]    ch_fixed [NIT+1];
    logic [2:0][SQW-1:0] ch_v    [NIT+1];
    logic [2:0][SQW-1:0] ch_root [NIT+1];
    logic [spu_pkg::OUT_BITS-1:0] perimeter;

    // unpack the six coordinates from the low end of the word
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            coord[i] = s_axis_tdata[i*C +: C];
        end
    end

    spu_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SQW        (SQW),
        .FIXW       (FIXW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (spu_pkg::op_t'(s_axis_tuser)),
        .in_coord  (coord),
        .in_radius (s_axis_tdata[6*C +: spu_pkg::RADIUS_BITS]),
        .out_valid (ch_valid[0]),
        .out_ready (ch_ready[0]),
        .out_op    (ch_op[0]),
        .out_fixed (ch_fixed[0]),
        .out_v     (ch_v[0])
    );

    // root starts at zero in every lane
    assign ch_root[0] = '0;

    for (genvar k = 0; k < NIT; k++)
    begin : g_cell
        spu_cell #(
            .SQW  (SQW),
            .NIT  (NIT),
            .IDX  (k),
            .FIXW (FIXW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ch_valid[k]),
            .in_ready  (ch_ready[k]),
            .in_op     (ch_op[k]),
            .in_fixed  (ch_fixed[k]),
            .in_v      (ch_v[k]),
            .in_root   (ch_root[k]),
            .out_valid (ch_valid[k+1]),
            .out_ready (ch_ready[k+1]),
            .out_op    (ch_op[k+1]),
            .out_fixed (ch_fixed[k+1]),
            .out_v     (ch_v[k+1]),
            .out_root  (ch_root[k+1])
        );
    end

    spu_back #(
        .SQW  (SQW),
        .NIT  (NIT),
        .FIXW (FIXW),
        .PW   (PW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ch_valid[NIT]),
        .in_ready  (ch_ready[NIT]),
        .in_op     (ch_op[NIT]),
        .in_fixed  (ch_fixed[NIT]),
        .in_root   (ch_root[NIT]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .perimeter (perimeter)
    );

    assign m_axis_tdata = spu_pkg::OUT_TDATA_BITS'(perimeter);

`ifndef SYNTH
    // an accepted word always lands in the first front stage
    a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> u_front.valid_reg[0])
        else $error("accepted word lost at chain entry");

    // the last cell hands a word over to the output register
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[NIT] && ch_ready[NIT] |=> m_axis_tvalid)
        else $error("word lost between chain and output");

    // unused shape code comes out as zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[NIT] && ch_ready[NIT] && (ch_op[NIT] == spu_pkg::OP_NONE)
        |=> perimeter == '0)
        else $error("unused shape gave a nonzero perimeter");
`endif

endmodule

/* rtl/spu_front.sv */
module spu_front #(
    parameter int COORD_BITS = spu_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spu_pkg::FRAC_BITS_DEF,
    parameter int SQW        = 2 * COORD_BITS + 2 + 2 * FRAC_BITS,
    parameter int FIXW       = 30
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  spu_pkg::op_t                          in_op,
    input  logic [5:0][COORD_BITS-1:0]            in_coord,  // ax ay bx by cx cy
    input  logic [spu_pkg::RADIUS_BITS-1:0]       in_radius,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output spu_pkg::op_t                          out_op,
    output logic [FIXW-1:0]                       out_fixed,
    output logic [2:0][SQW-1:0]                   out_v
);

    localparam int C  = COORD_BITS;
    localparam int PB = spu_pkg::PROD_BITS;
    localparam int LB = spu_pkg::LOW_BITS;
    localparam int SB = PB + 1;

    logic [3:0] valid_reg;
    logic [3:0] rdy;
    logic [3:0] ld;
    logic [3:0] vin;

    spu_pkg::op_t                op1_reg, op2_reg, op3_reg, op4_reg;
    logic [5:0][C-1:0]           d1_reg;
    logic [5:0][C-1:0]           d1_next;
    logic [spu_pkg::RADIUS_BITS-1:0] rad1_reg;
    logic [5:0][2*C-1:0]         sq2_reg;
    logic [PB-1:0]               plo2_reg, phi2_reg, phi3_reg;
    logic [FIXW-1:0]             rect2_reg, rect3_reg, fixed4_reg;
    logic [2:0][SQW-1:0]         v3_reg, v4_reg;
    logic [LB-1:0]               low3_reg;
    logic [SB-1:0]               csum;
    logic [FIXW-1:0]             fixed4_next;

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        logic signed [C:0] d;
        logic        [C:0] m;
        begin
            d = $signed({a[C-1], a}) - $signed({b[C-1], b});
            m = d[C] ? (~d + 1'b1) : d;
            abs_diff = m[C-1:0];
        end
    endfunction

    // pairs: AB, AC, BC as (dx, dy)
    always_comb
    begin
        d1_next[0] = abs_diff(in_coord[0], in_coord[2]);
        d1_next[1] = abs_diff(in_coord[1], in_coord[3]);
        d1_next[2] = abs_diff(in_coord[0], in_coord[4]);
        d1_next[3] = abs_diff(in_coord[1], in_coord[5]);
        d1_next[4] = abs_diff(in_coord[2], in_coord[4]);
        d1_next[5] = abs_diff(in_coord[3], in_coord[5]);
    end

    assign vin = {valid_reg[2:0], in_valid};
    assign rdy[3] = !valid_reg[3] || out_ready;
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];
    assign rdy[0] = !valid_reg[0] || rdy[1];
    assign ld = vin & rdy;
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= vin[i];
                end
            end
        end
    end

    assign csum = SB'(phi3_reg) + SB'(low3_reg[LB-1:32]);
    assign fixed4_next = (op3_reg == spu_pkg::OP_CIRCLE) ?
                         FIXW'(csum >> (spu_pkg::CIRC_SHIFT - FRAC_BITS)) : rect3_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            op1_reg  <= in_op;
            d1_reg   <= d1_next;
            rad1_reg <= in_radius;
        end
        if (ld[1])
        begin
            op2_reg <= op1_reg;
            for (int i = 0; i < 6; i++)
            begin
                sq2_reg[i] <= d1_reg[i] * d1_reg[i];
            end
            plo2_reg  <= PB'(rad1_reg) * PB'(spu_pkg::PI_Q60_LO);
            phi2_reg  <= PB'(rad1_reg) * PB'(spu_pkg::PI_Q60_HI);
            rect2_reg <= FIXW'((FIXW'(d1_reg[2]) + FIXW'(d1_reg[3])) << (FRAC_BITS + 1));
        end
        if (ld[2])
        begin
            op3_reg   <= op2_reg;
            rect3_reg <= rect2_reg;
            phi3_reg  <= phi2_reg;
            low3_reg  <= LB'(plo2_reg) + (LB'(1) << (58 - FRAC_BITS));
            for (int i = 0; i < 3; i++)
            begin
                v3_reg[i] <= (SQW'(sq2_reg[2*i]) + SQW'(sq2_reg[2*i+1])) << (2 * FRAC_BITS);
            end
        end
        if (ld[3])
        begin
            op4_reg    <= op3_reg;
            fixed4_reg <= fixed4_next;
            v4_reg     <= v3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_op    = op4_reg;
    assign out_fixed = fixed4_reg;
    assign out_v     = v4_reg;

endmodule

/* rtl/spu_cell.sv */
module spu_cell #(
    parameter int SQW  = 50,
    parameter int NIT  = 25,
    parameter int IDX  = 0,
    parameter int FIXW = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spu_pkg::op_t        in_op,
    input  logic [FIXW-1:0]     in_fixed,
    input  logic [2:0][SQW-1:0] in_v,
    input  logic [2:0][SQW-1:0] in_root,
    output logic                out_valid,
    input  logic                out_ready,
    output spu_pkg::op_t        out_op,
    output logic [FIXW-1:0]     out_fixed,
    output logic [2:0][SQW-1:0] out_v,
    output logic [2:0][SQW-1:0] out_root
);

    localparam logic [SQW:0] BIT = (SQW+1)'(1) << (2 * (NIT - 1 - IDX));

    logic                valid_reg;
    spu_pkg::op_t        op_reg;
    logic [FIXW-1:0]     fixed_reg;
    logic [2:0][SQW-1:0] v_reg, v_next, root_reg, root_next;
    logic [2:0][SQW:0]   trial;
    logic [2:0][SQW:0]   rem;

    // one restoring square-root step per lane
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {1'b0, in_root[i]} + BIT;
            rem[i]   = {1'b0, in_v[i]} - trial[i];
            if ({1'b0, in_v[i]} >= trial[i])
            begin
                v_next[i]    = rem[i][SQW-1:0];
                root_next[i] = (in_root[i] >> 1) + BIT[SQW-1:0];
            end
            else
            begin
                v_next[i]    = in_v[i];
                root_next[i] = in_root[i] >> 1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= in_op;
            fixed_reg <= in_fixed;
            v_reg     <= v_next;
            root_reg  <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_fixed = fixed_reg;
    assign out_v     = v_reg;
    assign out_root  = root_reg;

endmodule

/* rtl/spu_back.sv */
module spu_back #(
    parameter int SQW  = 50,
    parameter int NIT  = 25,
    parameter int FIXW = 30,
    parameter int PW   = 30
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  spu_pkg::op_t                    in_op,
    input  logic [FIXW-1:0]                 in_fixed,
    input  logic [2:0][SQW-1:0]             in_root,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [spu_pkg::OUT_BITS-1:0]    perimeter
);

    localparam int OB = spu_pkg::OUT_BITS;

    logic          valid_reg;
    logic [OB-1:0] perim_reg;
    logic [OB-1:0] perim_next;
    logic [PW-1:0] p;

    always_comb
    begin
        case (in_op) inside
            spu_pkg::OP_CIRCLE, spu_pkg::OP_RECT: p = PW'(in_fixed);
            spu_pkg::OP_TRI: p = PW'(in_root[0][NIT-1:0]) + PW'(in_root[1][NIT-1:0])
                                 + PW'(in_root[2][NIT-1:0]);
            default: p = '0;
        endcase
        // saturate
        perim_next = (|p[PW-1:OB]) ? {OB{1'b1}} : p[OB-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            perim_reg <= perim_next;
        end
    end

    assign out_valid = valid_reg;
    assign perimeter = perim_reg;

endmodule
